/* hw/rtl/spfa_pkg.sv */
`default_nettype none
package spfa_pkg;

  localparam int POOL_FRAMES     = 16;
  localparam int PAGES_PER_SPACE = 32;

  localparam int OPCODE_W = 1;
  localparam int ASID_W   = 6;
  localparam int PAGE_W   = 20;
  localparam int FRAME_W  = $clog2(POOL_FRAMES);
  localparam int ADDR_W   = 32;
  localparam int VPAGE_W  = $clog2(PAGES_PER_SPACE);

  localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'h2002_0000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FAULT   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic load;
    logic exec;
  } spfa_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/spfa_if.sv */
`default_nettype none
interface spfa_req_if;
  import spfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ASID_W-1:0]   asid;
  logic [PAGE_W-1:0]   page_number;

  modport source (output valid, output opcode, output asid, output page_number, input ready);
  modport sink   (input valid, input opcode, input asid, input page_number, output ready);
endinterface

interface spfa_rsp_if;
  import spfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame;
  logic [ADDR_W-1:0]  frame_address;
  logic               victim_valid;
  logic [ASID_W-1:0]  victim_asid;
  logic [VPAGE_W-1:0] victim_page;

  modport source (output valid, output frame, output frame_address, output victim_valid,
                  output victim_asid, output victim_page, input ready);
  modport sink   (input valid, input frame, input frame_address, input victim_valid,
                  input victim_asid, input victim_page, output ready);
endinterface
`default_nettype wire

/* hw/rtl/spfa_ctrl.sv */
`default_nettype none
module spfa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output spfa_pkg::spfa_cmd_t    cmd_o
);
  import spfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/spfa_dp.sv */
`default_nettype none
module spfa_dp #(
  parameter int FRAME_BYTES     = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire spfa_pkg::spfa_cmd_t           cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [spfa_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  wire logic [spfa_pkg::OPCODE_W-1:0] opcode_i,
  input  wire logic [spfa_pkg::ASID_W-1:0]   asid_i,
  input  wire logic [spfa_pkg::PAGE_W-1:0]   page_number_i,
  output logic      [spfa_pkg::FRAME_W-1:0]  frame_o,
  output logic      [spfa_pkg::ADDR_W-1:0]   frame_address_o,
  output logic                               victim_valid_o,
  output logic      [spfa_pkg::ASID_W-1:0]   victim_asid_o,
  output logic      [spfa_pkg::VPAGE_W-1:0]  victim_page_o
);
  import spfa_pkg::*;

  localparam int IDX_W = $clog2(POOL_FRAMES);
  localparam logic [PAGE_W-1:0]  PAGE_TOP   = PAGE_W'(PAGES_PER_SPACE - 1);
  localparam logic [IDX_W-1:0]   LAST_FRAME = IDX_W'(POOL_FRAMES - 1);
  localparam logic [ADDR_W-1:0]  FRAME_SIZE = ADDR_W'(FRAME_BYTES);

  logic [ADDR_W-1:0]   pool_base_q;
  logic [IDX_W-1:0]    rptr_q, rptr_d;
  logic                occ_q [POOL_FRAMES];
  logic                occ_d [POOL_FRAMES];
  logic [ASID_W-1:0]   owner_q [POOL_FRAMES];
  logic [VPAGE_W-1:0]  vpage_q [POOL_FRAMES];

  logic [OPCODE_W-1:0] op_q;
  logic [ASID_W-1:0]   asid_q;
  logic [VPAGE_W-1:0]  page_q;
  logic [PAGE_W-1:0]   page_clamped;

  logic                found;
  logic [IDX_W-1:0]    sel_free, sel;
  logic                is_release;
  logic [ADDR_W-1:0]   offset;

  assign page_clamped = (page_number_i >= PAGE_W'(PAGES_PER_SPACE)) ? PAGE_TOP : page_number_i;
  assign is_release   = (op_q == OP_RELEASE);

  always_comb begin
    found    = 1'b0;
    sel_free = '0;
    for (int i = POOL_FRAMES - 1; i >= 0; i--) begin
      if (!occ_q[i]) begin
        found    = 1'b1;
        sel_free = IDX_W'(i);
      end
    end
  end

  assign sel    = found ? sel_free : rptr_q;
  assign offset = ADDR_W'(sel) * FRAME_SIZE;

  always_comb begin
    rptr_d = rptr_q;
    for (int i = 0; i < POOL_FRAMES; i++) begin
      occ_d[i] = occ_q[i];
    end
    if (cmd_i.exec) begin
      if (is_release) begin
        for (int i = 0; i < POOL_FRAMES; i++) begin
          if (occ_q[i] && (owner_q[i] == asid_q)) begin
            occ_d[i] = 1'b0;
          end
        end
      end else begin
        occ_d[sel] = 1'b1;
        if (!found) begin
          rptr_d = (rptr_q == LAST_FRAME) ? '0 : rptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= POOL_BASE_RESET;
      rptr_q      <= '0;
      for (int i = 0; i < POOL_FRAMES; i++) begin
        occ_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        pool_base_q <= cfg_wdata_i;
      end
      rptr_q <= rptr_d;
      for (int i = 0; i < POOL_FRAMES; i++) begin
        occ_q[i] <= occ_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      asid_q <= asid_i;
      page_q <= page_clamped[VPAGE_W-1:0];
    end
    if (cmd_i.exec) begin
      if (is_release) begin
        frame_o         <= '0;
        frame_address_o <= '0;
        victim_valid_o  <= 1'b0;
        victim_asid_o   <= '0;
        victim_page_o   <= '0;
      end else begin
        frame_o         <= FRAME_W'(sel);
        frame_address_o <= pool_base_q + offset;
        victim_valid_o  <= occ_q[sel];
        victim_asid_o   <= occ_q[sel] ? owner_q[sel] : '0;
        victim_page_o   <= occ_q[sel] ? vpage_q[sel] : '0;
        owner_q[sel]    <= asid_q;
        vpage_q[sel]    <= page_q;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/swap_pool_frame_allocator_unit.sv */
// A result is registered in the table update step that follows the acceptance of its
// request transaction; the next request is accepted only after that update step;
// a pending result holds off the update step and with it the next accept.
// Reset (async, active low): all frames free, replacement pointer 0,
// pool base 0x20020000.
`default_nettype none
module swap_pool_frame_allocator_unit #(
  parameter int FRAME_BYTES     = 4096
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [spfa_pkg::ADDR_W-1:0] cfg_wdata_i,
  spfa_req_if.sink                         req_i,
  spfa_rsp_if.source                       rsp_o
);
  import spfa_pkg::*;

  spfa_cmd_t cmd;

  spfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  spfa_dp #(
    .FRAME_BYTES     (FRAME_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (req_i.opcode),
    .asid_i          (req_i.asid),
    .page_number_i   (req_i.page_number),
    .frame_o         (rsp_o.frame),
    .frame_address_o (rsp_o.frame_address),
    .victim_valid_o  (rsp_o.victim_valid),
    .victim_asid_o   (rsp_o.victim_asid),
    .victim_page_o   (rsp_o.victim_page)
  );

endmodule
`default_nettype wire

/* sim/swap_pool_frame_allocator_unit_tb.sv */
`timescale 1ns / 100ps
module swap_pool_frame_allocator_unit_tb;
  import spfa_pkg::*;

  localparam int NUM_FRAMES = 16;
  localparam int PAGES      = 32;
  localparam int FRAME_SIZE = 4096;
  localparam int PHASES     = 4;
  localparam int PHASE_ITEMS = 160;

  typedef struct {
    opcode_e           opcode;
    logic [ASID_W-1:0] asid;
    logic [PAGE_W-1:0] page_number;
  } page_request_t;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic [ADDR_W-1:0]  frame_address;
    logic               victim_valid;
    logic [ASID_W-1:0]  victim_asid;
    logic [VPAGE_W-1:0] victim_page;
  } frame_grant_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  spfa_req_if req_if ();
  spfa_rsp_if rsp_if ();

  swap_pool_frame_allocator_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  // predictor state
  logic [ADDR_W-1:0]  pool_base = POOL_BASE_RESET;
  logic               frame_busy [NUM_FRAMES];
  logic [ASID_W-1:0]  frame_asid [NUM_FRAMES];
  logic [VPAGE_W-1:0] frame_vpage [NUM_FRAMES];
  logic [FRAME_W-1:0] repl_ptr = '0;

  page_request_t request_q [$];
  frame_grant_t  grant_q [$];
  page_request_t cur_req;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int mismatch_count = 0;
  int faults_sent = 0;
  int releases_sent = 0;
  int evictions = 0;
  int grants_checked = 0;

  function automatic frame_grant_t allocate_frame(page_request_t r);
    frame_grant_t       g;
    logic [VPAGE_W-1:0] vp;
    int                 sel;
    bit                 found;
    g = '{default: '0};
    sel = 0;
    found = 1'b0;
    if (r.opcode == OP_RELEASE) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (frame_busy[i] && frame_asid[i] == r.asid) frame_busy[i] = 1'b0;
      end
      return g;
    end
    vp = (r.page_number >= PAGES) ? VPAGE_W'(PAGES - 1) : r.page_number[VPAGE_W-1:0];
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!frame_busy[i]) begin
        sel = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      sel = repl_ptr;
      repl_ptr = repl_ptr + 1'b1;
    end
    g.frame = FRAME_W'(sel);
    g.frame_address = pool_base + ADDR_W'(sel * FRAME_SIZE);
    if (frame_busy[sel]) begin
      g.victim_valid = 1'b1;
      g.victim_asid = frame_asid[sel];
      g.victim_page = frame_vpage[sel];
    end
    frame_busy[sel] = 1'b1;
    frame_asid[sel] = r.asid;
    frame_vpage[sel] = vp;
    return g;
  endfunction

  function automatic page_request_t random_request();
    page_request_t r;
    r.opcode = ($urandom_range(99) < 12) ? OP_RELEASE : OP_FAULT;
    r.asid = ($urandom_range(3) == 0) ? ASID_W'($urandom_range(63)) : ASID_W'($urandom_range(5));
    case ($urandom_range(3))
      0: r.page_number = PAGE_W'($urandom);
      1: r.page_number = PAGE_W'($urandom_range(20'hFFFFF, PAGES));
      default: r.page_number = PAGE_W'($urandom_range(PAGES - 1));
    endcase
    return r;
  endfunction

  task automatic push_req(opcode_e op, int asid, int page);
    page_request_t r;
    r.opcode = op;
    r.asid = ASID_W'(asid);
    r.page_number = PAGE_W'(page);
    request_q.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    while (request_q.size() != 0 || req_if.valid || grant_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (cur_req.opcode == OP_RELEASE) releases_sent++;
        else faults_sent++;
        grant_q.push_back(allocate_frame(cur_req));
      end
      if (!req_if.valid || req_if.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = request_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.opcode <= cur_req.opcode;
          req_if.asid <= cur_req.asid;
          req_if.page_number <= cur_req.page_number;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_grant_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (grant_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transaction, expected none, got frame %h", $time,
                   rsp_if.frame);
        end else begin
          want = grant_q.pop_front();
          grants_checked++;
          if (want.victim_valid) evictions++;
          check_field("frame", ADDR_W'(want.frame), ADDR_W'(rsp_if.frame));
          check_field("frame_address", want.frame_address, rsp_if.frame_address);
          check_field("victim_valid", ADDR_W'(want.victim_valid), ADDR_W'(rsp_if.victim_valid));
          check_field("victim_asid", ADDR_W'(want.victim_asid), ADDR_W'(rsp_if.victim_asid));
          check_field("victim_page", ADDR_W'(want.victim_page), ADDR_W'(rsp_if.victim_page));
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  initial begin
    #200000;
    $display("swap_pool_frame_allocator_unit regression: fail");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] base_list [PHASES];
    int                send_list [PHASES];
    int                stall_list [PHASES];
    req_if.valid = 1'b0;
    req_if.opcode = OP_FAULT;
    req_if.asid = '0;
    req_if.page_number = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_busy[i] = 1'b0;
      frame_asid[i] = '0;
      frame_vpage[i] = '0;
    end
    base_list = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'hFFFF_8001};
    base_list[2] = $urandom;
    send_list = '{0, 47, 0, 26};
    stall_list = '{0, 0, 47, 26};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pass at the reset pool base
    push_req(OP_RELEASE, 5, 0);
    push_req(OP_FAULT, 0, 0);
    push_req(OP_FAULT, 63, 31);
    push_req(OP_FAULT, 1, 32);
    push_req(OP_FAULT, 2, 20'hFFFFF);
    for (int i = 4; i < NUM_FRAMES; i++) push_req(OP_FAULT, 3, i);
    push_req(OP_FAULT, 4, 7);
    push_req(OP_FAULT, 4, 8);
    push_req(OP_RELEASE, 3, 0);
    push_req(OP_RELEASE, 3, 0);
    push_req(OP_FAULT, 7, 20'h55555);
    push_req(OP_FAULT, 42, 20'hAAAAA);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= base_list[p];
      pool_base = base_list[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      send_idle_pct = send_list[p];
      rsp_stall_pct = stall_list[p];
      for (int i = 0; i < PHASE_ITEMS / 2; i++) request_q.push_back(random_request());
      // hold off mid-phase until all results are back
      drain();
      for (int i = 0; i < PHASE_ITEMS / 2; i++) request_q.push_back(random_request());
      drain();
    end

    repeat (8) @(negedge clk);
    $display("covered %0d faults with %0d evictions and %0d releases, %0d results checked",
             faults_sent, evictions, releases_sent, grants_checked);
    $display("pool base taken through reset, all-ones, zero, random and a wrapping value");
    if (mismatch_count == 0) begin
      $display("swap_pool_frame_allocator_unit regression: pass");
    end else begin
      $display("swap_pool_frame_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
